[sv/tmt_pkg.sv]
// shared types and constants for the typed field magic test core
`default_nettype none

package tmt_pkg;

  // field widths of the input and result beats
  localparam int unsigned WindowW = 64;
  localparam int unsigned AvailW  = 4;
  localparam int unsigned WcodeW  = 2;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InFieldsW  = 2 * WindowW + AvailW + WcodeW + ModeW + 4;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = StatusW + AvailW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // cap on bytes_available: the eight bytes of the window
  localparam logic [AvailW-1:0] MaxAvail = AvailW'(8);

  // comparison operators
  typedef enum logic [ModeW-1:0] {
    MODE_NONE = 3'd0,
    MODE_EQ   = 3'd1,
    MODE_LT   = 3'd2,
    MODE_GT   = 3'd3,
    MODE_SET  = 3'd4,
    MODE_CLR  = 3'd5
  } mode_t;

  // field width codes
  typedef enum logic [WcodeW-1:0] {
    WIDTH_1 = 2'd0,
    WIDTH_2 = 2'd1,
    WIDTH_4 = 2'd2,
    WIDTH_8 = 2'd3
  } width_t;

  // result status
  typedef enum logic [StatusW-1:0] {
    ST_FAIL  = 2'd0,
    ST_MATCH = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // one input beat, declared from the highest field down
  typedef struct packed {
    logic                negate;
    logic                invert;
    logic [ModeW-1:0]    mode;
    logic [WindowW-1:0]  test_value;
    logic                signed_mode;
    logic                big_endian;
    logic [WcodeW-1:0]   width_code;
    logic [AvailW-1:0]   bytes_available;
    logic [WindowW-1:0]  window;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [AvailW-1:0] consumed_bytes;
    status_t           status;
  } out_beat_t;

endpackage

`default_nettype wire

[sv/typed_field_magic_test_core.sv]
// typed numeric field test core: field extraction, extension and compare
//
// Usage: one input beat on s_axis carries an eight-byte window of file data
// at the test offset, the bytes left, the field width code, byte order,
// signedness, a 64-bit test value, the operator and the invert and negate
// flags. Each input beat gives exactly one result beat on m_axis with a
// status (fail, match, or error when too few bytes remain) and the number
// of bytes the field consumed on a match.
// Pipeline: input register, then result register with the whole test in
// between.
// Throughput: one beat per cycle while m_tready stays high; the 64-bit
// negate and magnitude compare between the two registers set the path.
// Reset: rst clears both valid flags; no beats are held afterwards.
// Stall: when m_tready is low the result holds; the input register keeps
// filling and s_tready drops once both stages are full, so no beat is lost.
`default_nettype none

module typed_field_magic_test_core (
  input  wire                               clk,
  input  wire                               rst,
  // fields from bit 0: window[63:0], bytes_available[67:64],
  // width_code[69:68], big_endian[70], signed_mode[71], test_value[135:72],
  // mode[138:136], invert[139], negate[140], zero pad
  input  wire  [tmt_pkg::InDataW-1:0]       s_axis_tdata,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: status[1:0], consumed_bytes[5:2], zero pad
  output logic [tmt_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready
);

  localparam logic [tmt_pkg::WindowW-1:0] Sign64 = {1'b1, {(tmt_pkg::WindowW-1){1'b0}}};

  // pipeline advance control
  logic advance;
  logic in_valid;
  tmt_pkg::in_beat_t in_beat;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_beat <= tmt_pkg::in_beat_t'(s_axis_tdata[tmt_pkg::InFieldsW-1:0]);
    end
  end

  // field width and byte check
  logic [tmt_pkg::AvailW-1:0] nbytes;
  logic [tmt_pkg::AvailW-1:0] avail_sat;
  logic                       short_data;

  assign nbytes     = tmt_pkg::AvailW'(1) << in_beat.width_code;
  assign avail_sat  = (in_beat.bytes_available > tmt_pkg::MaxAvail) ?
                      tmt_pkg::MaxAvail : in_beat.bytes_available;
  assign short_data = avail_sat < nbytes;

  // field extraction in the chosen byte order, then extension
  logic [63:0] w;
  logic [63:0] field_raw;
  logic [63:0] field_ext;
  logic [63:0] field_val;

  assign w = in_beat.window;

  always_comb begin
    case (tmt_pkg::width_t'(in_beat.width_code))
      tmt_pkg::WIDTH_1: begin
        field_raw = {56'd0, w[7:0]};
        field_ext = {{56{w[7] & in_beat.signed_mode}}, field_raw[7:0]};
      end
      tmt_pkg::WIDTH_2: begin
        field_raw = in_beat.big_endian ? {48'd0, w[7:0], w[15:8]} : {48'd0, w[15:0]};
        field_ext = {{48{field_raw[15] & in_beat.signed_mode}}, field_raw[15:0]};
      end
      tmt_pkg::WIDTH_4: begin
        field_raw = in_beat.big_endian ?
                    {32'd0, w[7:0], w[15:8], w[23:16], w[31:24]} : {32'd0, w[31:0]};
        field_ext = {{32{field_raw[31] & in_beat.signed_mode}}, field_raw[31:0]};
      end
      default: begin
        field_raw = in_beat.big_endian ?
                    {w[7:0], w[15:8], w[23:16], w[31:24],
                     w[39:32], w[47:40], w[55:48], w[63:56]} : w;
        field_ext = field_raw;
      end
    endcase
  end

  // negate on the signed path only
  assign field_val = (in_beat.signed_mode && in_beat.negate) ? (64'd0 - field_ext) : field_ext;

  // comparison, signed by flipping the sign bits
  logic [63:0] test_key;
  logic [63:0] field_key;
  logic        cmp_ok;
  logic        ok;

  assign test_key  = in_beat.signed_mode ? (in_beat.test_value ^ Sign64) : in_beat.test_value;
  assign field_key = in_beat.signed_mode ? (field_val ^ Sign64) : field_val;

  always_comb begin
    case (tmt_pkg::mode_t'(in_beat.mode))
      tmt_pkg::MODE_EQ:  cmp_ok = in_beat.test_value == field_val;
      tmt_pkg::MODE_LT:  cmp_ok = test_key < field_key;
      tmt_pkg::MODE_GT:  cmp_ok = test_key > field_key;
      tmt_pkg::MODE_SET: cmp_ok = (in_beat.test_value & field_val) == in_beat.test_value;
      tmt_pkg::MODE_CLR: cmp_ok = (~in_beat.test_value & field_val) == 64'd0;
      default:           cmp_ok = 1'b0;
    endcase
  end

  assign ok = cmp_ok ^ in_beat.invert;

  // result beat
  tmt_pkg::out_beat_t res_next;
  tmt_pkg::out_beat_t res;

  always_comb begin
    if (short_data) begin
      res_next.status         = tmt_pkg::ST_ERROR;
      res_next.consumed_bytes = '0;
    end else if (ok) begin
      res_next.status         = tmt_pkg::ST_MATCH;
      res_next.consumed_bytes = nbytes;
    end else begin
      res_next.status         = tmt_pkg::ST_FAIL;
      res_next.consumed_bytes = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {{(tmt_pkg::OutDataW - tmt_pkg::OutFieldsW){1'b0}}, res};

  // a held input beat is kept while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_beat)))
    else $error("input register lost a beat during stall");

  // a match always reports a legal field width, anything else reports zero
  a_consumed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((res.status == tmt_pkg::ST_MATCH) ?
      (res.consumed_bytes == 4'd1 || res.consumed_bytes == 4'd2 ||
       res.consumed_bytes == 4'd4 || res.consumed_bytes == 4'd8) :
      (res.consumed_bytes == 4'd0)))
    else $error("consumed byte count does not agree with status");

  // a beat in the input register reaches the output when the output is free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> m_axis_tvalid)
    else $error("accepted beat did not reach the result register");

  // no status code beyond error
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.status != 2'd3))
    else $error("undefined status code on output");

endmodule

`default_nettype wire
